FILE: rtl/core/fss_pkg.sv
`default_nettype none

package fss_pkg;

  // Sizing
  localparam int QUERY_MAX   = 32;
  localparam int INDEX_WIDTH = 16;
  localparam int LEN_W       = $clog2(QUERY_MAX + 1);
  localparam int IDX_W       = $clog2(QUERY_MAX);
  localparam int POS_W       = IDX_W;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_QUERY = 2'd1,
    OP_CHAR  = 2'd2,
    OP_END   = 2'd3
  } fss_op_t;

  typedef enum logic [1:0] {
    RANK_EXACT    = 2'd0,
    RANK_PREFIX   = 2'd1,
    RANK_CONTAINS = 2'd2,
    RANK_NONE     = 2'd3
  } fss_rank_t;

  typedef enum logic {
    S_RUN   = 1'b0,
    S_DRAIN = 1'b1
  } fss_state_t;

  typedef struct packed {
    fss_op_t    opcode;
    logic [7:0] char_code;
  } fss_item_t;

  typedef struct packed {
    logic [15:0] candidate_index;
    fss_rank_t   match_rank;
    logic [7:0]  edit_distance;
    logic        is_match;
    logic [7:0]  text_length;
  } fss_result_t;

  // One candidate character moving down the cell row
  typedef struct packed {
    logic             valid;
    logic [7:0]       chr;
    logic [7:0]       left_new;
    logic [7:0]       left_old;
    logic             hit_old;
    logic             pos_live;
    logic [POS_W-1:0] pos_left;
  } fss_wave_t;

  // What each cell reports to the scorer
  typedef struct packed {
    logic [7:0] row_val;
    logic       broke;
    logic       seen;
  } fss_cell_stat_t;

  // ASCII case folding
  function automatic logic [7:0] fold_char(input logic [7:0] c);
    fold_char = (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
  endfunction

  // Tab, line feed, vertical tab, form feed, carriage return and space
  function automatic logic is_blank(input logic [7:0] c);
    is_blank = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/fuzzy_search_match_scorer.sv
`default_nettype none

// Streaming fuzzy matcher: load a query with append items (leading blanks
// dropped, trailing blanks ignored at scoring, ASCII case-insensitive), then
// stream candidate characters; each candidate end item yields the candidate's
// index, rank (exact, prefix, contains, none), Levenshtein distance, length and
// match flag, with non-matches dropped unless include_all is set. Clear, append
// and candidate character items are taken back to back with no stall: each
// character enters a row of QUERY_MAX cells that hold one query character and
// one distance entry apiece, and moves one cell per cycle. A candidate end item
// stalls the input while the last character leaves the cell row and while the
// result register stays full. No clearing pass follows reset.
module fuzzy_search_match_scorer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  fss_pkg::fss_item_t   item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output fss_pkg::fss_result_t result,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata
);
  import fss_pkg::*;

  fss_state_t             state;
  fss_state_t             state_next;
  logic [LEN_W-1:0]       query_len;
  logic [LEN_W-1:0]       q_eff;
  logic [15:0]            cand_len;
  logic [INDEX_WIDTH-1:0] cand_count;
  logic                   include_all;
  fss_wave_t              inject;

  fss_wave_t              wave [QUERY_MAX];
  fss_cell_stat_t         cell_stat [QUERY_MAX];

  logic                   accept;
  logic                   drain_done;
  logic                   clear_cand;
  logic                   chain_busy;
  logic                   slot_free;
  logic [7:0]             c;
  logic                   c_blank;
  logic                   do_append;
  logic [15:0]            cand_len_next;

  logic                   broke_any;
  logic                   seen_any;
  logic [IDX_W-1:0]       q_last;
  logic [7:0]             dist_q;
  logic [15:0]            q_ext;
  logic [15:0]            field;
  logic [15:0]            triple;
  logic                   q_zero;
  fss_rank_t              rank;
  logic [7:0]             score_dist;
  logic                   score_match;
  logic                   emit;

  // Decode the input item
  assign accept    = item_valid && !item_stall;
  assign c         = fold_char(item.char_code);
  assign c_blank   = is_blank(c);
  assign do_append = accept && (item.opcode == OP_QUERY) &&
                     !((query_len == '0) && c_blank) &&
                     (query_len < LEN_W'(QUERY_MAX));
  assign slot_free = !result_valid || !result_stall;
  assign cand_len_next = (cand_len == 16'hFFFF) ? cand_len : cand_len + 16'd1;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_RUN: begin
        if (accept && (item.opcode == OP_END)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!chain_busy && slot_free) begin
          state_next = S_RUN;
        end
      end
      default: state_next = S_RUN;
    endcase
  end

  // State outputs
  always_comb begin
    item_stall = 1'b1;
    drain_done = 1'b0;
    unique case (state)
      S_RUN: begin
        item_stall = 1'b0;
      end
      S_DRAIN: begin
        drain_done = !chain_busy && slot_free;
      end
      default: item_stall = 1'b1;
    endcase
  end

  assign clear_cand = drain_done ||
                      (accept && ((item.opcode == OP_CLEAR) || (item.opcode == OP_QUERY)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN;
    end else begin
      state <= state_next;
    end
  end

  // Hold the configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      include_all <= 1'b0;
    end else if (cfg_we) begin
      include_all <= cfg_wdata;
    end
  end

  // Track query length and its length without trailing blanks
  always_ff @(posedge clk) begin
    if (rst) begin
      query_len <= '0;
      q_eff     <= '0;
    end else if (accept && (item.opcode == OP_CLEAR)) begin
      query_len <= '0;
      q_eff     <= '0;
    end else if (do_append) begin
      query_len <= query_len + 1'b1;
      if (!c_blank) begin
        q_eff <= query_len + 1'b1;
      end
    end
  end

  // Count candidates since the last query clear
  always_ff @(posedge clk) begin
    if (rst) begin
      cand_count <= '0;
    end else if (accept && (item.opcode == OP_CLEAR)) begin
      cand_count <= '0;
    end else if (drain_done) begin
      cand_count <= cand_count + 1'b1;
    end
  end

  // Inject candidate characters at the head of the cell row
  always_ff @(posedge clk) begin
    if (rst || clear_cand) begin
      cand_len     <= '0;
      inject.valid <= 1'b0;
    end else if (accept && (item.opcode == OP_CHAR)) begin
      cand_len        <= cand_len_next;
      inject.valid    <= 1'b1;
      inject.chr      <= c;
      inject.left_new <= (cand_len_next[15:8] != '0) ? 8'hFF : cand_len_next[7:0];
      inject.left_old <= (cand_len[15:8] != '0) ? 8'hFF : cand_len[7:0];
      inject.hit_old  <= 1'b1;
      inject.pos_live <= (cand_len < 16'(QUERY_MAX));
      inject.pos_left <= cand_len[POS_W-1:0];
    end else begin
      inject.valid <= 1'b0;
    end
  end

  // Build the cell row
  for (genvar k = 0; k < QUERY_MAX; k++) begin : g_cell
    localparam int ROW_INIT = (k + 1 > 255) ? 255 : k + 1;
    fss_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .clear     (clear_cand),
      .wave_in   ((k == 0) ? inject : wave[(k == 0) ? 0 : k - 1]),
      .wave_out  (wave[k]),
      .load      (do_append && (query_len == LEN_W'(k))),
      .load_char (c),
      .in_query  (LEN_W'(k) < q_eff),
      .is_last   (q_eff == LEN_W'(k + 1)),
      .row_init  (8'(ROW_INIT)),
      .stat      (cell_stat[k])
    );
  end

  // Gather busy and sticky flags from the row
  always_comb begin
    chain_busy = inject.valid;
    broke_any  = 1'b0;
    seen_any   = 1'b0;
    for (int k = 0; k < QUERY_MAX; k++) begin
      chain_busy = chain_busy | wave[k].valid;
      broke_any  = broke_any | cell_stat[k].broke;
      seen_any   = seen_any | cell_stat[k].seen;
    end
  end

  // Score the finished candidate
  always_comb begin
    q_zero = (q_eff == '0);
    q_ext  = 16'(q_eff);
    q_last = IDX_W'(q_eff - 1'b1);
    dist_q = cell_stat[q_last].row_val;
    field  = (cand_len < q_ext) ? cand_len : q_ext;
    triple = 16'({dist_q, 1'b0}) + 16'(dist_q);
    if (q_zero) begin
      rank = RANK_NONE;
    end else if (!broke_any && (cand_len == q_ext)) begin
      rank = RANK_EXACT;
    end else if (!broke_any && (cand_len >= q_ext)) begin
      rank = RANK_PREFIX;
    end else if (seen_any) begin
      rank = RANK_CONTAINS;
    end else begin
      rank = RANK_NONE;
    end
    score_dist  = q_zero ? 8'd0 : dist_q;
    score_match = q_zero || (rank != RANK_NONE) || (dist_q <= 8'd1) || (triple <= field);
    emit        = include_all || score_match;
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (drain_done && emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain_done && emit) begin
      result.candidate_index <= 16'(cand_count);
      result.match_rank      <= rank;
      result.edit_distance   <= score_dist;
      result.is_match        <= score_match;
      result.text_length     <= (cand_len[15:8] != '0) ? 8'hFF : cand_len[7:0];
    end
  end

  // A cleared candidate leaves no character in flight
  assert property (@(posedge clk) disable iff (rst) clear_cand |=> !chain_busy)
    else $error("character in flight after candidate clear");

  // Effective query length never exceeds the stored length
  assert property (@(posedge clk) disable iff (rst) q_eff <= query_len)
    else $error("effective query length above stored length");

  // A new result comes only out of the drain state
  assert property (@(posedge clk) disable iff (rst)
      $rose(result_valid) |-> $past(state == S_DRAIN))
    else $error("result loaded outside drain");

  // A non-matching result appears only with include_all set
  assert property (@(posedge clk) disable iff (rst)
      $rose(result_valid) && !result.is_match |-> include_all)
    else $error("non-match emitted with include_all clear");

  // A candidate end item blocks the input on the next cycle
  assert property (@(posedge clk) disable iff (rst)
      accept && (item.opcode == OP_END) |=> item_stall)
    else $error("input not held after candidate end");

endmodule

`default_nettype wire

FILE: rtl/core/fss_cell.sv
`default_nettype none

module fss_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    clear,
  input  fss_pkg::fss_wave_t      wave_in,
  output fss_pkg::fss_wave_t      wave_out,
  input  logic                    load,
  input  logic [7:0]              load_char,
  input  logic                    in_query,
  input  logic                    is_last,
  input  logic [7:0]              row_init,
  output fss_pkg::fss_cell_stat_t stat
);
  import fss_pkg::*;

  logic [7:0] qchar;
  logic [7:0] row_val;
  logic       hit;
  logic       broke;
  logic       seen;

  logic       eq;
  logic [8:0] cost_up;
  logic [8:0] cost_left;
  logic [8:0] cost_diag;
  logic [8:0] best;
  logic [7:0] row_val_next;
  logic       hit_next;
  logic       pos_here;

  // Compute this cell's entry of the next distance row
  always_comb begin
    eq        = (wave_in.chr == qchar);
    cost_up   = {1'b0, row_val} + 9'd1;
    cost_left = {1'b0, wave_in.left_new} + 9'd1;
    cost_diag = {1'b0, wave_in.left_old} + {8'd0, ~eq};
    best      = cost_up;
    if (cost_left < best) begin
      best = cost_left;
    end
    if (cost_diag < best) begin
      best = cost_diag;
    end
    row_val_next = best[8] ? 8'hFF : best[7:0];
    hit_next     = wave_in.hit_old && eq;
    pos_here     = wave_in.pos_live && (wave_in.pos_left == '0);
  end

  // Hold the query character
  always_ff @(posedge clk) begin
    if (load) begin
      qchar <= load_char;
    end
  end

  // Update cell state and pass the character on
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      row_val        <= row_init;
      hit            <= 1'b0;
      broke          <= 1'b0;
      seen           <= 1'b0;
      wave_out.valid <= 1'b0;
    end else if (wave_in.valid) begin
      row_val <= row_val_next;
      hit     <= hit_next;
      if (hit_next && is_last) begin
        seen <= 1'b1;
      end
      if (pos_here && in_query && !eq) begin
        broke <= 1'b1;
      end
      wave_out.valid    <= 1'b1;
      wave_out.chr      <= wave_in.chr;
      wave_out.left_new <= row_val_next;
      wave_out.left_old <= row_val;
      wave_out.hit_old  <= hit;
      wave_out.pos_live <= wave_in.pos_live && (wave_in.pos_left != '0);
      wave_out.pos_left <= wave_in.pos_left - 1'b1;
    end else begin
      wave_out.valid <= 1'b0;
    end
  end

  assign stat.row_val = row_val;
  assign stat.broke   = broke;
  assign stat.seen    = seen;

endmodule

`default_nettype wire

FILE: tb/sv/fuzzy_search_match_scorer_tb.sv
`timescale 1ns / 1ps

module fuzzy_search_match_scorer_tb;
  import fss_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  fss_item_t   item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  fss_result_t result;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;

  fuzzy_search_match_scorer i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Stimulus and scoreboard storage
  fss_item_t   pending_items[$];
  fss_result_t expected_results[$];
  int          pushed_count = 0;
  int          accepted_count = 0;
  int          error_count = 0;

  // Flow control knobs
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_done = 0;
  int hold_left = 0;

  // Scorer state mirror
  logic [7:0]  q_chars [QUERY_MAX];
  int          q_count;
  int          d_row [QUERY_MAX+1];
  int          c_len;
  bit          prefix_alive;
  bit          tail_hits [QUERY_MAX];
  bit          contains_seen;
  logic [15:0] cand_number;
  bit          emit_all;

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic int sat8(int v);
    return (v > 255) ? 255 : v;
  endfunction

  // Query length with trailing blanks left out
  function automatic int trimmed_len();
    int n;
    n = q_count;
    while (n > 0 && is_space(q_chars[n-1]))
      n--;
    return n;
  endfunction

  function automatic void restart_candidate();
    for (int j = 0; j <= QUERY_MAX; j++)
      d_row[j] = sat8(j);
    foreach (tail_hits[j])
      tail_hits[j] = 1'b0;
    c_len = 0;
    prefix_alive = 1'b1;
    contains_seen = 1'b0;
  endfunction

  // Fold one candidate character into the distance row and match flags
  function automatic void take_cand_char(logic [7:0] c);
    int q, pos, diag, up, best, left, sub;
    q = trimmed_len();
    pos = c_len;
    if (c_len < 65535)
      c_len++;
    diag = d_row[0];
    d_row[0] = sat8(c_len);
    for (int j = 1; j <= q; j++) begin
      up = d_row[j];
      best = up + 1;
      left = d_row[j-1] + 1;
      sub = diag + ((q_chars[j-1] == c) ? 0 : 1);
      if (left < best) best = left;
      if (sub < best) best = sub;
      diag = up;
      d_row[j] = sat8(best);
    end
    if (pos < q && q_chars[pos] != c)
      prefix_alive = 1'b0;
    if (q > 0) begin
      for (int j = q - 1; j > 0; j--)
        tail_hits[j] = tail_hits[j-1] && (q_chars[j] == c);
      tail_hits[0] = (q_chars[0] == c);
      if (tail_hits[q-1])
        contains_seen = 1'b1;
    end
  endfunction

  // Advance the mirror by one accepted item, queue any result it causes
  function automatic void score_item(fss_item_t it);
    logic [7:0]  c;
    int          q, edist, field, max_dist;
    bit          hit;
    fss_result_t r;
    c = to_lower(it.char_code);
    case (it.opcode)
      OP_CLEAR: begin
        q_count = 0;
        cand_number = '0;
        restart_candidate();
      end
      OP_QUERY: begin
        if (!(q_count == 0 && is_space(c)) && q_count < QUERY_MAX) begin
          q_chars[q_count] = c;
          q_count++;
        end
        restart_candidate();
      end
      OP_CHAR: begin
        take_cand_char(c);
      end
      default: begin
        q = trimmed_len();
        if (q == 0) begin
          r.match_rank = RANK_NONE;
          edist = 0;
          hit = 1'b1;
        end else begin
          if (prefix_alive && c_len == q)
            r.match_rank = RANK_EXACT;
          else if (prefix_alive && c_len >= q)
            r.match_rank = RANK_PREFIX;
          else if (contains_seen)
            r.match_rank = RANK_CONTAINS;
          else
            r.match_rank = RANK_NONE;
          edist = d_row[q];
          field = (q < c_len) ? q : c_len;
          max_dist = field / 3;
          if (max_dist < 1)
            max_dist = 1;
          hit = (r.match_rank != RANK_NONE) || (edist <= max_dist);
        end
        r.candidate_index = cand_number;
        r.edit_distance = edist[7:0];
        r.is_match = hit;
        r.text_length = 8'(sat8(c_len));
        cand_number++;
        restart_candidate();
        if (emit_all || hit)
          expected_results = {expected_results, r};
      end
    endcase
  endfunction

  // Offer the next pending item once the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || !item_stall) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        item <= pending_items.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Stall results at random, or for a long stretch on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_stall <= 1'b1;
    end else if (hold_req != hold_done) begin
      hold_left <= 300;
      hold_done <= hold_req;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Check results against the oldest expectation, then mirror accepted items
  always @(posedge clk) begin
    fss_result_t want;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got index %0d rank %0d dist %0d",
                   $time, result.candidate_index, result.match_rank, result.edit_distance);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("candidate_index", want.candidate_index, result.candidate_index);
          check_field("match_rank", want.match_rank, result.match_rank);
          check_field("edit_distance", want.edit_distance, result.edit_distance);
          check_field("is_match", want.is_match, result.is_match);
          check_field("text_length", want.text_length, result.text_length);
        end
      end
      if (item_valid && !item_stall) begin
        score_item(item);
        accepted_count++;
      end
    end
  end

  task automatic add_item(fss_op_t op, logic [7:0] ch);
    fss_item_t it;
    it.opcode = op;
    it.char_code = ch;
    pending_items = {pending_items, it};
    pushed_count++;
  endtask

  function automatic logic [7:0] pick_char();
    string alpha;
    int    r;
    alpha = "abcAB";
    r = $urandom_range(99);
    if (r < 55)
      return alpha[$urandom_range(4)];
    if (r < 65) begin
      case ($urandom_range(2))
        0: return 8'd32;
        1: return 8'd9;
        default: return 8'd13;
      endcase
    end
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] flip_case(logic [7:0] c);
    if (c >= 8'd97 && c <= 8'd122 && $urandom_range(1))
      return c - 8'd32;
    if (c >= 8'd65 && c <= 8'd90 && $urandom_range(1))
      return c + 8'd32;
    return c;
  endfunction

  // Mostly query-then-candidates sessions, with some noise and broken runs
  task automatic add_random_items(int target);
    int         start, qn, r, kind, len, pos;
    logic [7:0] qtext[$];
    logic [7:0] ctext[$];
    start = pushed_count;
    while (pushed_count - start < target) begin
      if ($urandom_range(99) < 8) begin
        add_item(fss_op_t'($urandom_range(3)), 8'($urandom_range(255)));
        continue;
      end
      if ($urandom_range(99) < 85) begin
        add_item(OP_CLEAR, 8'($urandom_range(255)));
        qtext.delete();
      end
      r = $urandom_range(99);
      if (r < 88)
        qn = $urandom_range(1, 6);
      else if (r < 96)
        qn = $urandom_range(10, 32);
      else
        qn = $urandom_range(33, 40);
      repeat (qn) begin
        qtext = {qtext, pick_char()};
        add_item(OP_QUERY, qtext[$]);
      end
      repeat ($urandom_range(1, 6)) begin
        ctext.delete();
        kind = $urandom_range(99);
        if (kind < 55) begin
          // exact, prefix or contains shapes built around the query
          if (kind >= 40)
            repeat ($urandom_range(1, 3)) ctext = {ctext, pick_char()};
          foreach (qtext[i])
            ctext = {ctext, flip_case(qtext[i])};
          if (kind >= 25)
            repeat ($urandom_range(kind < 40 ? 1 : 0, 4)) ctext = {ctext, pick_char()};
        end else if (kind < 75) begin
          // near miss: a copy with one or two edits
          foreach (qtext[i])
            ctext = {ctext, flip_case(qtext[i])};
          repeat ($urandom_range(1, 2)) begin
            if (ctext.size() == 0) begin
              ctext = {ctext, pick_char()};
            end else begin
              pos = $urandom_range(ctext.size() - 1);
              case ($urandom_range(2))
                0: ctext[pos] = pick_char();
                1: ctext.delete(pos);
                default: ctext.insert(pos, pick_char());
              endcase
            end
          end
        end else begin
          len = (kind < 97) ? $urandom_range(0, 8) : $urandom_range(256, 300);
          repeat (len) ctext = {ctext, pick_char()};
        end
        foreach (ctext[i])
          add_item(OP_CHAR, ctext[i]);
        // break off some candidates by touching the query
        r = $urandom_range(99);
        if (r < 2) begin
          qtext = {qtext, pick_char()};
          add_item(OP_QUERY, qtext[$]);
        end else if (r < 3) begin
          add_item(OP_CLEAR, 8'($urandom_range(255)));
          qtext.delete();
        end else begin
          add_item(OP_END, 8'($urandom_range(255)));
        end
      end
    end
  endtask

  // Hold until everything sent is taken and scored, then let the block settle
  task automatic wait_drained();
    while (accepted_count != pushed_count)
      @(posedge clk);
    while (expected_results.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_include_all(bit v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    emit_all = v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(bit incl, int idle_pct, int stall_pct, bit long_hold);
    set_include_all(incl);
    sender_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    add_random_items(175);
    if (long_hold)
      hold_req++;
    wait_drained();
  endtask

  initial begin
    q_count = 0;
    cand_number = '0;
    emit_all = 1'b0;
    restart_candidate();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_include_all(1'b0);

    // Directed: blank handling, case folding, exact, contains and no-match ranks, empty query, extremes
    add_item(OP_CLEAR, 8'hFF);
    add_item(OP_QUERY, 8'd32);
    add_item(OP_QUERY, "A");
    add_item(OP_QUERY, "b");
    add_item(OP_QUERY, "C");
    add_item(OP_QUERY, 8'd9);
    add_item(OP_CHAR, "a");
    add_item(OP_CHAR, "B");
    add_item(OP_CHAR, "c");
    add_item(OP_END, 8'h00);
    add_item(OP_CHAR, "x");
    add_item(OP_CHAR, "a");
    add_item(OP_CHAR, "b");
    add_item(OP_CHAR, "C");
    add_item(OP_END, 8'hFF);
    add_item(OP_END, 8'h55);
    add_item(OP_CHAR, "a");
    add_item(OP_CHAR, 8'hFF);
    add_item(OP_END, 8'hAA);
    add_item(OP_CHAR, "z");
    add_item(OP_QUERY, "d");
    add_item(OP_CLEAR, 8'h00);
    add_item(OP_END, 8'h00);
    add_item(OP_CHAR, 8'h00);
    add_item(OP_END, 8'hFF);
    wait_drained();

    run_phase(1'b1, 0, 0, 1'b1);
    run_phase(1'b0, 80, 0, 1'b0);
    run_phase(1'b1, 0, 80, 1'b0);
    run_phase(1'b0, 37, 37, 1'b0);

    if (error_count == 0) begin
      $display("fuzzy_search_match_scorer_tb passed");
    end else begin
      $display("fuzzy_search_match_scorer_tb failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("fuzzy_search_match_scorer_tb failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/fss_pkg.sv
rtl/core/fss_cell.sv
rtl/core/fuzzy_search_match_scorer.sv
tb/sv/fuzzy_search_match_scorer_tb.sv
